/* rtl/dsq_pkg.sv */
// Shared types and codes for the deadline sleep queue.
`timescale 1ns / 1ps

package dsq_pkg;

  localparam int CountW = 64;
  localparam int IdW    = 8;
  localparam int TicksW = 32;

  // kind codes of an input beat
  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // event codes of a result beat
  localparam logic [1:0] EV_WOKEN  = 2'd0;
  localparam logic [1:0] EV_QUEUED = 2'd1;
  localparam logic [1:0] EV_FULL   = 2'd2;

  typedef struct packed {
    logic                     kind;
    logic [IdW-1:0]           thread_id;
    logic signed [TicksW-1:0] sleep_ticks;
  } item_t;

  typedef struct packed {
    logic [1:0]     event_res;
    logic [IdW-1:0] woken_id;
    logic           last;
  } result_t;

  // one queue slot
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] wake;
    logic [IdW-1:0]    id;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [CountW-1:0] wake;
    logic [IdW-1:0]    id;
    logic [CountW-1:0] count;
  } cell_ctl_t;

endpackage

/* rtl/dsq_cell.sv */
// One slot of the sorted sleeper chain.
`timescale 1ns / 1ps

module dsq_cell (
  input  logic               clk,
  input  logic               rst,
  input  dsq_pkg::cell_ctl_t ctl,
  input  dsq_pkg::entry_t    left,
  input  logic               left_open,
  input  dsq_pkg::entry_t    right,
  output dsq_pkg::entry_t    entry,
  output logic               open,
  output logic               due
);
  import dsq_pkg::*;

  // slot gives way to a new wake time that sorts strictly before it
  assign open = !entry.valid || (ctl.wake < entry.wake);
  assign due  = entry.valid && (entry.wake <= ctl.count);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      case (ctl.op)
        OP_INSERT: begin
          if (open) begin
            if (left_open) begin
              entry <= left;
            end else begin
              entry <= '{valid: 1'b1, wake: ctl.wake, id: ctl.id};
            end
          end
        end
        OP_POP: begin
          entry <= right;
        end
        default: begin
          entry <= entry;
        end
      endcase
    end
  end

endmodule

/* rtl/deadline_sleep_queue.sv */
// Top level of the deadline sleep queue: controller, tick counter and cell chain.
`timescale 1ns / 1ps

// Sorted deadline timer queue.
// Input: a beat is taken at a rising edge with start high and busy low.
//   kind = sleep: wake time = count + sleep_ticks (non-positive -> count,
//   saturating at all ones); the sleeper is sorted in after every entry with
//   an equal or earlier wake time. One result: queued, or full (dropped).
//   kind = tick: the 64-bit count advances (saturating), then every due head
//   entry is released in order, one woken result per cycle, last marked.
// Output: each result sits on result for one cycle with strobe high; the
//   receiver cannot stall, so no back-pressure exists.
// Timing: a sleep beat keeps busy high while its wake time, registered at
//   the accept edge, goes through one parallel compare-and-shift across
//   the chain; its result is registered as busy falls, and the next beat
//   is taken only once busy is low again. A tick beat keeps busy high in
//   the release state while due sleepers remain at the head, one pop of
//   the chain per cycle through the head cell, and enters that state even
//   when none is due; one tick releases at most QUEUE_DEPTH sleepers.
// Reset: clears the count, the valid bit of every cell, the state and the
//   strobe; slot payloads, the captured request and result stay as they are.
module deadline_sleep_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dsq_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output dsq_pkg::result_t result
);
  import dsq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_RELEASE
  } state_t;

  state_t            state;
  logic [CountW-1:0] count;
  logic [CountW-1:0] wake;
  logic [IdW-1:0]    wake_id;

  logic              accept;
  logic              ticks_pos;
  logic [CountW:0]   wake_sum;
  logic [CountW-1:0] wake_next;
  logic              full;

  cell_ctl_t         ctl;
  entry_t            entries [QUEUE_DEPTH];
  entry_t            lefts   [QUEUE_DEPTH];
  entry_t            rights  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] opens;
  logic [QUEUE_DEPTH-1:0] left_opens;
  logic [QUEUE_DEPTH-1:0] dues;
  logic [QUEUE_DEPTH-1:0] valids;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Wake time: non-positive requests wake at the current count.
  assign ticks_pos = !item.sleep_ticks[TicksW-1] && (item.sleep_ticks != '0);
  assign wake_sum  = {1'b0, count} + {{(CountW+1-TicksW){1'b0}}, item.sleep_ticks};
  always_comb begin
    if (!ticks_pos) begin
      wake_next = count;
    end else if (wake_sum[CountW]) begin
      wake_next = '1;
    end else begin
      wake_next = wake_sum[CountW-1:0];
    end
  end

  // Queue is full when the tail cell holds a sleeper.
  assign full = entries[QUEUE_DEPTH-1].valid;

  // Broadcast control: insert on a sleep with room, pop on a due head.
  always_comb begin
    ctl.wake  = wake;
    ctl.id    = wake_id;
    ctl.count = count;
    ctl.op    = OP_HOLD;
    case (state)
      S_INSERT:  if (!full) ctl.op = OP_INSERT;
      S_RELEASE: if (dues[0]) ctl.op = OP_POP;
      default:   ctl.op = OP_HOLD;
    endcase
  end

  // Cell chain: each cell sees its left and right neighbor.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign lefts[g]      = '0;
      assign left_opens[g] = 1'b0;
    end else begin : g_body
      assign lefts[g]      = entries[g-1];
      assign left_opens[g] = opens[g-1];
    end
    if (g == QUEUE_DEPTH-1) begin : g_tail
      assign rights[g] = '0;
    end else begin : g_inner
      assign rights[g] = entries[g+1];
    end
    assign valids[g] = entries[g].valid;

    dsq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (lefts[g]),
      .left_open (left_opens[g]),
      .right     (rights[g]),
      .entry     (entries[g]),
      .open      (opens[g]),
      .due       (dues[g])
    );
  end

  // Controller: state, count, captured request and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_TICK) begin
              // advance the count, hold at all ones
              if (count != '1) count <= count + 1'b1;
              state <= S_RELEASE;
            end else begin
              wake    <= wake_next;
              wake_id <= item.thread_id;
              state   <= S_INSERT;
            end
          end
        end
        S_INSERT: begin
          strobe           <= 1'b1;
          result.event_res <= full ? EV_FULL : EV_QUEUED;
          result.woken_id  <= wake_id;
          result.last      <= 1'b1;
          state            <= S_IDLE;
        end
        S_RELEASE: begin
          if (dues[0]) begin
            // release the head; the next cell decides whether more follow
            strobe           <= 1'b1;
            result.event_res <= EV_WOKEN;
            result.woken_id  <= entries[0].id;
            result.last      <= !dues[1 % QUEUE_DEPTH] || (QUEUE_DEPTH < 2);
            if (!dues[1 % QUEUE_DEPTH]) state <= S_IDLE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Valid slots always form a contiguous run from the head.
  a_contig: assert property (@(posedge clk) disable iff (rst)
    ((valids & (valids + 1'b1)) == '0))
    else $error("gap in the sleeper chain");

  // A full report only when the tail was occupied.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.event_res == EV_FULL) |-> $past(full))
    else $error("full reported with room left");

  // The count never moves backward.
  a_count: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count >= $past(count)))
    else $error("tick count went backward");

  // A woken result comes only out of the release state.
  a_woken: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.event_res == EV_WOKEN) |-> $past(state == S_RELEASE))
    else $error("wake result outside release");

  // Head never sorts after its neighbor.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (QUEUE_DEPTH > 1 && entries[1 % QUEUE_DEPTH].valid) |->
      (entries[0].wake <= entries[1 % QUEUE_DEPTH].wake))
    else $error("head out of order");

endmodule
